// File: src/gnmc_pkg.sv
// Shared types and constants for the grid neighbor mine counter.
// No dependencies; used by every module under src.
`default_nettype none

package gnmc_pkg;

  // Default largest grid edge, and the reset value of the grid size register.
  localparam int unsigned MAX_SIZE_DEF  = 32;
  localparam int unsigned GRID_SIZE_W   = 6;
  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 6'd32;

  // Result encoding.
  localparam int unsigned VALUE_W   = 5;
  localparam int unsigned COUNT_W   = 4;
  localparam logic [VALUE_W-1:0] MINE_VALUE = 5'h1F;

  // Register map: word index taken from paddr[2].
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic REG_GRID_SIZE    = 1'b0;

  // One column of the two line buffers.
  typedef struct packed {
    logic prv;
    logic cur;
  } line_bits_t;

  // Which sides of the 3x3 window lie outside the grid for the result cell.
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic first_col;
    logic last_col;
  } border_t;

endpackage

`default_nettype wire

// File: src/gnmc_line_cell.sv
// One column cell of the two-row line buffer chain.
// Depends on gnmc_pkg for the line_bits_t type.
`default_nettype none

module gnmc_line_cell (
  input  wire                     clk_i,
  input  wire                     shift_i,
  input  wire                     load_sel_i,
  input  gnmc_pkg::line_bits_t    new_i,
  input  gnmc_pkg::line_bits_t    left_i,
  output gnmc_pkg::line_bits_t    q_o
);

  gnmc_pkg::line_bits_t bits_q;
  gnmc_pkg::line_bits_t bits_d;

  // The entry cell takes the fresh column; every other cell takes its left neighbor.
  assign bits_d = load_sel_i ? new_i : left_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      bits_q <= bits_d;
    end
  end

  assign q_o = bits_q;

endmodule

`default_nettype wire

// File: src/gnmc_count.sv
// Mine count over a 3x3 window with out-of-grid neighbors masked off.
// Depends on gnmc_pkg for border_t and the result constants.
`default_nettype none

module gnmc_count (
  input  wire [8:0]                         window_i,
  input  gnmc_pkg::border_t                 border_i,
  output logic [gnmc_pkg::VALUE_W-1:0]      value_o
);

  logic [8:0]                       mask;
  logic [gnmc_pkg::COUNT_W-1:0]     total;

  // Bit index is column * 3 + row; column 0 is the oldest (left) column.
  always_comb begin
    mask = 9'h1FF;
    mask[4] = 1'b0;
    if (border_i.first_col) begin
      mask[2:0] = 3'b000;
    end
    if (border_i.last_col) begin
      mask[8:6] = 3'b000;
    end
    if (border_i.first_row) begin
      mask[0] = 1'b0;
      mask[3] = 1'b0;
      mask[6] = 1'b0;
    end
    if (border_i.last_row) begin
      mask[2] = 1'b0;
      mask[5] = 1'b0;
      mask[8] = 1'b0;
    end
  end

  always_comb begin
    total = '0;
    for (int b = 0; b < 9; b++) begin
      total = total + gnmc_pkg::COUNT_W'(window_i[b] & mask[b]);
    end
  end

  assign value_o = window_i[4] ? gnmc_pkg::MINE_VALUE
                               : {{(gnmc_pkg::VALUE_W-gnmc_pkg::COUNT_W){1'b0}}, total};

endmodule

`default_nettype wire

// File: src/grid_neighbor_mine_count.sv
// Top level of the streamed minesweeper neighbor counter.
// Depends on gnmc_pkg, gnmc_line_cell and gnmc_count.
`default_nettype none

// Channel   Direction  Handshake                        Payload
// input     in         in_valid_i / in_ready_o          is_mine_i
// output    out        out_valid_o / out_ready_i        cell_value_o, last_cell_o
// config    in         psel & penable & pwrite & pready paddr, pwdata, prdata
//
// One cell word is taken per cycle; its result leaves one row plus one cell later.
// The final cell of a grid starts a flush of N+1 filler pushes, one per cycle, which
// give N+1 further results (only one when N is 1); no input word is taken meanwhile.
// The rate is set by the single window push per cycle into the line cell chain. Reset
// clears counters, window and grid size (32); the line cells hold no reset value.
// A stalled output holds the push.

module grid_neighbor_mine_count #(
  parameter int unsigned MaxSize = gnmc_pkg::MAX_SIZE_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // cell input
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              is_mine_i,
  // result output
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic signed [gnmc_pkg::VALUE_W-1:0] cell_value_o,
  output logic                             last_cell_o,
  // configuration
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [gnmc_pkg::PADDR_W-1:0]     paddr,
  input  wire  [gnmc_pkg::PDATA_W-1:0]     pwdata,
  output logic [gnmc_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam int unsigned CW = $clog2(MaxSize);
  localparam int unsigned NW = $clog2(MaxSize + 1);
  localparam int unsigned RW = $clog2(MaxSize + 2);

  // Configuration register.
  logic [gnmc_pkg::GRID_SIZE_W-1:0] grid_size_q;
  logic                             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == gnmc_pkg::REG_GRID_SIZE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == gnmc_pkg::REG_GRID_SIZE) begin
      prdata = {{(gnmc_pkg::PDATA_W-gnmc_pkg::GRID_SIZE_W){1'b0}}, grid_size_q};
    end
  end

  // Effective grid edge, clamped to 1..MaxSize.
  logic [NW-1:0] n_w;
  always_comb begin
    if (grid_size_q == '0) begin
      n_w = NW'(1);
    end else if (int'(grid_size_q) > int'(MaxSize)) begin
      n_w = NW'(MaxSize);
    end else begin
      n_w = NW'(grid_size_q);
    end
  end

  // Position of the next pushed cell, flush flag, window and output register.
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          flush_q, flush_d;
  logic [8:0]    window_q, window_d, window_next;
  logic          out_valid_q;
  logic [gnmc_pkg::VALUE_W-1:0] value_q;
  logic          last_q;

  logic out_free, in_fire, push;
  logic cur_bit;
  logic at_grid_end, at_row_end, at_flush_end;
  logic [RW-1:0] n_r;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = !flush_q && out_free;
  assign in_fire = in_valid_i && in_ready_o;
  assign push = in_fire || (flush_q && out_free);
  assign cur_bit = flush_q ? 1'b0 : is_mine_i;

  assign n_r = RW'(n_w);
  assign at_row_end   = (NW'(col_q) == n_w - NW'(1));
  assign at_grid_end  = (row_q == n_r - RW'(1)) && at_row_end;
  assign at_flush_end = (row_q == n_r + RW'(1));

  // Line buffer chain: the entry cell sits MaxSize - N from the start, so the
  // tap at the far end is N pushes behind.
  logic [CW-1:0] entry;
  gnmc_pkg::line_bits_t cell_q [MaxSize];
  gnmc_pkg::line_bits_t tap, fresh;

  assign entry = CW'(int'(MaxSize) - int'(n_w));
  assign tap   = cell_q[MaxSize-1];
  assign fresh = '{prv: tap.cur, cur: cur_bit};

  for (genvar k = 0; k < MaxSize; k++) begin : g_cell
    gnmc_line_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (push),
      .load_sel_i (entry == CW'(k)),
      .new_i      (fresh),
      .left_i     ((k == 0) ? fresh : cell_q[(k == 0) ? 0 : k-1]),
      .q_o        (cell_q[k])
    );
  end

  assign window_next = {cur_bit, tap.cur, tap.prv, window_q[8:3]};

  // Result position and borders, one row plus one cell behind the push.
  gnmc_pkg::border_t border;
  logic emit;
  logic [gnmc_pkg::VALUE_W-1:0] value;

  always_comb begin
    if (col_q != '0) begin
      emit             = (row_q >= RW'(1));
      border.first_row = (row_q == RW'(1));
      border.last_row  = (row_q == n_r);
      border.first_col = (col_q == CW'(1));
      border.last_col  = 1'b0;
    end else begin
      emit             = (row_q >= RW'(2));
      border.first_row = (row_q == RW'(2));
      border.last_row  = at_flush_end;
      border.first_col = (n_w == NW'(1));
      border.last_col  = 1'b1;
    end
  end

  gnmc_count u_count (
    .window_i (window_next),
    .border_i (border),
    .value_o  (value)
  );

  // Next position: a real push walks the grid, a flush push walks the filler rows.
  always_comb begin
    row_d    = row_q;
    col_d    = col_q;
    flush_d  = flush_q;
    window_d = window_q;
    if (push) begin
      window_d = window_next;
      if (!flush_q) begin
        if (at_grid_end) begin
          flush_d = 1'b1;
          row_d   = n_r;
          col_d   = '0;
        end else if (at_row_end) begin
          row_d = row_q + RW'(1);
          col_d = '0;
        end else begin
          col_d = col_q + CW'(1);
        end
      end else if (at_flush_end) begin
        flush_d  = 1'b0;
        row_d    = '0;
        col_d    = '0;
        window_d = '0;
      end else if (at_row_end) begin
        row_d = n_r + RW'(1);
        col_d = '0;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= gnmc_pkg::GRID_SIZE_RST;
      row_q       <= '0;
      col_q       <= '0;
      flush_q     <= 1'b0;
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (cfg_wr) begin
      // A size write restarts the grid and drops pending results.
      grid_size_q <= pwdata[gnmc_pkg::GRID_SIZE_W-1:0];
      row_q       <= '0;
      col_q       <= '0;
      flush_q     <= 1'b0;
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_q    <= row_d;
      col_q    <= col_d;
      flush_q  <= flush_d;
      window_q <= window_d;
      if (out_free) begin
        out_valid_q <= push && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && out_free) begin
      value_q <= value;
      last_q  <= flush_q && at_flush_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = value_q;
  assign last_cell_o  = last_q;

endmodule

`default_nettype wire

// File: dv/grid_neighbor_mine_count_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_neighbor_mine_count: streams mine grids of many sizes
// and checks every neighbor count against an in-bench scoreboard.
// Depends on gnmc_pkg and the grid_neighbor_mine_count RTL only.

module grid_neighbor_mine_count_tb;

  localparam int unsigned MAX_CELLS    = gnmc_pkg::MAX_SIZE_DEF * gnmc_pkg::MAX_SIZE_DEF;
  localparam int unsigned TARGET_CELLS = 310;
  localparam int unsigned SETTLE_CYC   = 16;
  localparam int unsigned TAIL_CYC     = 64;
  localparam int unsigned LIMIT_CYC    = 200000;

  typedef struct packed {
    logic [gnmc_pkg::VALUE_W-1:0] value;
    logic                         last;
  } cell_result_t;

  // Keeps the cells of the grid in progress and the counts still owed by the block.
  class mine_count_board;
    int                     grid_n;
    int                     fill;
    int                     next_out;
    bit                     cells [MAX_CELLS];
    cell_result_t           due_q [$];
    int unsigned            failures;

    function new();
      write_size(gnmc_pkg::GRID_SIZE_RST);
      failures = 0;
    endfunction

    // A size write restarts the grid; out-of-range sizes are clamped.
    function void write_size(logic [gnmc_pkg::GRID_SIZE_W-1:0] v);
      if (v == 0) grid_n = 1;
      else if (v > gnmc_pkg::MAX_SIZE_DEF) grid_n = gnmc_pkg::MAX_SIZE_DEF;
      else grid_n = v;
      fill     = 0;
      next_out = 0;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void note_cell(bit mine);
      int           upto, r, c, rr, cc, t;
      bit           grid_done;
      cell_result_t res;
      cells[fill] = mine;
      grid_done = (fill == grid_n * grid_n - 1);
      // A count is due once its lower-right neighbor is in; the final cell flushes the rest.
      upto = grid_done ? fill : fill - (grid_n + 1);
      while (next_out <= upto) begin
        r = next_out / grid_n;
        c = next_out % grid_n;
        if (cells[next_out]) begin
          res.value = gnmc_pkg::MINE_VALUE;
        end else begin
          t = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              rr = r + dr;
              cc = c + dc;
              if ((dr != 0 || dc != 0) && rr >= 0 && rr < grid_n && cc >= 0 && cc < grid_n)
                t += cells[rr * grid_n + cc];
            end
          end
          res.value = t[gnmc_pkg::VALUE_W-1:0];
        end
        res.last = (next_out == grid_n * grid_n - 1);
        due_q.push_back(res);
        next_out++;
      end
      if (grid_done) begin
        fill     = 0;
        next_out = 0;
      end else begin
        fill++;
      end
    endfunction

    function void check_result(logic [gnmc_pkg::VALUE_W-1:0] v, logic l);
      cell_result_t want;
      if (due_q.size() == 0) begin
        $error("unexpected word: cell_value %0d last_cell %0b", $signed(v), l);
        failures++;
        return;
      end
      want = due_q.pop_front();
      if (v !== want.value) begin
        $error("cell_value: expected %0d, actual %0d", $signed(want.value), $signed(v));
        failures++;
      end
      if (l !== want.last) begin
        $error("last_cell: expected %0b, actual %0b", want.last, l);
        failures++;
      end
    endfunction
  endclass

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic                                 is_mine_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic signed [gnmc_pkg::VALUE_W-1:0]  cell_value_o;
  logic                                 last_cell_o;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [gnmc_pkg::PADDR_W-1:0]         paddr;
  logic [gnmc_pkg::PDATA_W-1:0]         pwdata;
  logic [gnmc_pkg::PDATA_W-1:0]         prdata;
  logic                                 pready;

  mine_count_board board = new();
  int unsigned     sent_cells = 0;
  int unsigned     cycle_count = 0;
  int unsigned     gap_pct = 0;
  int unsigned     stall_pct = 0;

  grid_neighbor_mine_count dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .is_mine_i    (is_mine_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_value_o (cell_value_o),
    .last_cell_o  (last_cell_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(cell_value_o, last_cell_o);
  end

  // Result side: random stall bursts while stall_pct is nonzero.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Valid is left high after the word is taken so back-to-back words need no re-raise.
  task automatic send_cell(input bit mine);
    in_valid_i <= 1'b1;
    is_mine_i  <= mine;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_cell(mine);
    sent_cells++;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // The size is only changed once every owed count has come out and the block has settled.
  task automatic program_grid_size(input logic [gnmc_pkg::GRID_SIZE_W-1:0] v);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {gnmc_pkg::REG_GRID_SIZE, 2'b00};
    pwdata  <= {{(gnmc_pkg::PDATA_W-gnmc_pkg::GRID_SIZE_W){1'b0}}, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_size(v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned sz, cnt, dens, n;
    bit [8:0]    ring_cells;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    is_mine_i  <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stall_pct = 20;

    // Partial grid at the reset size, enough for the first few counts.
    repeat (36) send_cell($urandom_range(0, 1));

    // Single-cell grids, including the size of zero that acts as one.
    program_grid_size(6'd1);
    send_cell(1'b1);
    send_cell(1'b0);
    program_grid_size(6'd0);
    send_cell(1'b1);

    // Clear center surrounded by eight mines gives the top count.
    program_grid_size(6'd3);
    ring_cells = 9'b111101111;
    for (int i = 0; i < 9; i++) send_cell(ring_cells[i]);

    // A size write in the middle of a grid drops it and starts over.
    program_grid_size(6'd2);
    send_cell(1'b1);
    send_cell(1'b1);
    program_grid_size(6'd2);
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b0);
    send_cell(1'b1);

    // Largest register value clamps to the maximum grid edge.
    program_grid_size(6'd63);
    repeat (36) send_cell($urandom_range(0, 1));

    while (sent_cells < TARGET_CELLS) begin
      if (sent_cells >= TARGET_CELLS * 4 / 5) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 15; stall_pct = 15; end
          default: begin gap_pct = 40; stall_pct = 40; end
        endcase
      end
      sz = $urandom_range(0, 99);
      if (sz < 8) sz = $urandom_range(32, 63);
      else if (sz < 22) sz = $urandom_range(7, 9);
      else sz = $urandom_range(0, 6);
      if (board.fill != 0 || $urandom_range(0, 3) != 0)
        program_grid_size(sz[gnmc_pkg::GRID_SIZE_W-1:0]);
      n = board.grid_n;
      // Large grids are only run far enough to produce some counts.
      cnt = (n > 16) ? $urandom_range(34, 48) : n * n;
      if (n <= 16 && cnt > 1 && $urandom_range(0, 9) == 0) cnt = $urandom_range(1, cnt - 1);
      if (cnt > TARGET_CELLS - sent_cells) cnt = TARGET_CELLS - sent_cells;
      dens = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 100 : 0)
                                         : $urandom_range(10, 90);
      repeat (cnt) send_cell($urandom_range(0, 99) < dens);
    end

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
